>>> rtl/core/assert_macros.svh
// Assertion macros shared by the queue manager modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHK_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mllqm_pkg.sv
// Shared constants, micro-op codes and types of the linked queue manager.
package mllqm_pkg;

  localparam int NUM_LISTS   = 4;
  localparam int NUM_ENTRIES = 256;
  localparam int LW          = $clog2(NUM_LISTS);
  localparam int EW          = $clog2(NUM_ENTRIES);
  localparam int PW          = $clog2(NUM_ENTRIES + 1);
  localparam int SLOTS       = NUM_LISTS * NUM_ENTRIES;
  localparam int SW          = LW + EW;

  localparam logic [PW-1:0] LINK_NONE = PW'(NUM_ENTRIES);

  localparam logic [2:0] CMD_PUSH     = 3'd0;
  localparam logic [2:0] CMD_REMOVE   = 3'd1;
  localparam logic [2:0] CMD_SHIFT    = 3'd2;
  localparam logic [2:0] CMD_CONTAINS = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;
  localparam logic [2:0] CMD_GRAB     = 3'd5;

  localparam int UW = 5;
  localparam logic [UW-1:0] UOP_NOP       = 5'd0;
  localparam logic [UW-1:0] UOP_LOAD      = 5'd1;
  localparam logic [UW-1:0] UOP_INIT      = 5'd2;
  localparam logic [UW-1:0] UOP_PUSH_RD   = 5'd3;
  localparam logic [UW-1:0] UOP_PUSH_A    = 5'd4;
  localparam logic [UW-1:0] UOP_PUSH_B    = 5'd5;
  localparam logic [UW-1:0] UOP_REM_RD    = 5'd6;
  localparam logic [UW-1:0] UOP_REM_A     = 5'd7;
  localparam logic [UW-1:0] UOP_REM_B     = 5'd8;
  localparam logic [UW-1:0] UOP_SHF_RD    = 5'd9;
  localparam logic [UW-1:0] UOP_SHF_A     = 5'd10;
  localparam logic [UW-1:0] UOP_SHF_B     = 5'd11;
  localparam logic [UW-1:0] UOP_CLR_INIT  = 5'd12;
  localparam logic [UW-1:0] UOP_CLR_RD    = 5'd13;
  localparam logic [UW-1:0] UOP_CLR_DROP  = 5'd14;
  localparam logic [UW-1:0] UOP_CLR_END   = 5'd15;
  localparam logic [UW-1:0] UOP_GRB_INIT  = 5'd16;
  localparam logic [UW-1:0] UOP_GRB_RD    = 5'd17;
  localparam logic [UW-1:0] UOP_GRB_CPY   = 5'd18;
  localparam logic [UW-1:0] UOP_GRB_DROP  = 5'd19;
  localparam logic [UW-1:0] UOP_GRB_LINK  = 5'd20;
  localparam logic [UW-1:0] UOP_GRB_EMPTY = 5'd21;
  localparam logic [UW-1:0] UOP_FIN_RD    = 5'd22;
  localparam logic [UW-1:0] UOP_OUT       = 5'd23;

  typedef struct packed {
    logic mbr;
    logic cnt_zero;
    logic hd_none;
    logic walk_done;
    logic same_list;
    logic init_done;
  } dp_status_t;

  function automatic logic [SW-1:0] slot_of(input logic [LW-1:0] l, input logic [PW-1:0] p);
    return {l, p[EW-1:0]};
  endfunction

endpackage

>>> rtl/core/mllqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mllqm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/mllqm_ctrl.sv
// Sequencer of the queue manager: steps each command through its micro-ops.
`include "assert_macros.svh"
module mllqm_ctrl import mllqm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [2:0]    command,
  input  dp_status_t    status,
  output logic [UW-1:0] uop,
  output logic          busy,
  output logic          out_strobe
);

  localparam logic [UW-1:0] ST_IDLE      = UOP_NOP;
  localparam logic [UW-1:0] ST_INIT      = UOP_INIT;
  localparam logic [UW-1:0] ST_PUSH_RD   = UOP_PUSH_RD;
  localparam logic [UW-1:0] ST_PUSH_A    = UOP_PUSH_A;
  localparam logic [UW-1:0] ST_PUSH_B    = UOP_PUSH_B;
  localparam logic [UW-1:0] ST_REM_RD    = UOP_REM_RD;
  localparam logic [UW-1:0] ST_REM_A     = UOP_REM_A;
  localparam logic [UW-1:0] ST_REM_B     = UOP_REM_B;
  localparam logic [UW-1:0] ST_SHF_RD    = UOP_SHF_RD;
  localparam logic [UW-1:0] ST_SHF_A     = UOP_SHF_A;
  localparam logic [UW-1:0] ST_SHF_B     = UOP_SHF_B;
  localparam logic [UW-1:0] ST_CLR_INIT  = UOP_CLR_INIT;
  localparam logic [UW-1:0] ST_CLR_RD    = UOP_CLR_RD;
  localparam logic [UW-1:0] ST_CLR_DROP  = UOP_CLR_DROP;
  localparam logic [UW-1:0] ST_CLR_END   = UOP_CLR_END;
  localparam logic [UW-1:0] ST_GRB_INIT  = UOP_GRB_INIT;
  localparam logic [UW-1:0] ST_GRB_RD    = UOP_GRB_RD;
  localparam logic [UW-1:0] ST_GRB_CPY   = UOP_GRB_CPY;
  localparam logic [UW-1:0] ST_GRB_DROP  = UOP_GRB_DROP;
  localparam logic [UW-1:0] ST_GRB_LINK  = UOP_GRB_LINK;
  localparam logic [UW-1:0] ST_GRB_EMPTY = UOP_GRB_EMPTY;
  localparam logic [UW-1:0] ST_FIN_RD    = UOP_FIN_RD;
  localparam logic [UW-1:0] ST_OUT       = UOP_OUT;

  logic [UW-1:0] state_r, state_nxt;
  logic          accept;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_OUT);
  assign uop        = (state_r == ST_IDLE) ? (accept ? UOP_LOAD : UOP_NOP) : state_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:      if (status.init_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_PUSH:   state_nxt = ST_PUSH_RD;
            CMD_REMOVE: state_nxt = ST_REM_RD;
            CMD_SHIFT:  state_nxt = ST_SHF_RD;
            CMD_CLEAR:  state_nxt = ST_CLR_INIT;
            CMD_GRAB:   state_nxt = ST_GRB_INIT;
            default:    state_nxt = ST_FIN_RD;
          endcase
        end
      end
      ST_PUSH_RD:   state_nxt = ST_PUSH_A;
      ST_PUSH_A:    state_nxt = status.mbr ? ST_FIN_RD : ST_PUSH_B;
      ST_PUSH_B:    state_nxt = ST_FIN_RD;
      ST_REM_RD:    state_nxt = ST_REM_A;
      ST_REM_A:     state_nxt = (status.cnt_zero || !status.mbr) ? ST_FIN_RD : ST_REM_B;
      ST_REM_B:     state_nxt = ST_FIN_RD;
      ST_SHF_RD:    state_nxt = (status.cnt_zero || status.hd_none) ? ST_FIN_RD : ST_SHF_A;
      ST_SHF_A:     state_nxt = ST_SHF_B;
      ST_SHF_B:     state_nxt = ST_FIN_RD;
      ST_CLR_INIT:  state_nxt = ST_CLR_RD;
      ST_CLR_RD:    state_nxt = status.walk_done ? ST_CLR_END : ST_CLR_DROP;
      ST_CLR_DROP:  state_nxt = ST_CLR_RD;
      ST_CLR_END:   state_nxt = ST_FIN_RD;
      ST_GRB_INIT:  state_nxt = (status.same_list || status.cnt_zero) ? ST_FIN_RD : ST_GRB_RD;
      ST_GRB_RD:    state_nxt = status.walk_done ? ST_GRB_LINK : ST_GRB_CPY;
      ST_GRB_CPY:   state_nxt = ST_GRB_DROP;
      ST_GRB_DROP:  state_nxt = ST_GRB_RD;
      ST_GRB_LINK:  state_nxt = ST_GRB_EMPTY;
      ST_GRB_EMPTY: state_nxt = ST_FIN_RD;
      ST_FIN_RD:    state_nxt = ST_OUT;
      ST_OUT:       state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CHK_NXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held longer than one cycle")
  `CHK_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")

endmodule

>>> rtl/core/mllqm_dp.sv
// Datapath: link memories, per-list head/tail/count and the walk registers.
`include "assert_macros.svh"
module mllqm_dp import mllqm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [UW-1:0] uop,
  input  logic [1:0]    in_list_id,
  input  logic [7:0]    in_entry_index,
  input  logic [1:0]    in_source_list_id,
  output dp_status_t    status,
  output logic [7:0]    out_result_entry,
  output logic          out_result_valid,
  output logic          out_is_member,
  output logic [8:0]    out_list_size,
  output logic [8:0]    out_list_head,
  output logic [8:0]    out_list_tail
);

  logic [LW-1:0] l_r, src_r;
  logic [EW-1:0] e_r, pop_r;
  logic [PW-1:0] cur_r, n_r, h_r, steps_r, hs_r, ts_r, cs_r;
  logic          valid_r;
  logic [SW-1:0] clr_addr_r;

  logic [PW-1:0] hd_r [NUM_LISTS];
  logic [PW-1:0] tl_r [NUM_LISTS];
  logic [PW-1:0] cnt_r [NUM_LISTS];

  logic [LW-1:0] lx, lst_wi;
  logic [PW-1:0] hd_x, tl_x, cnt_x, hd_nxt, tl_nxt, cnt_nxt;
  logic          lst_we;
  logic [PW:0]   sum;
  logic [PW-1:0] e_ptr;

  logic          n_we, p_we, m_we;
  logic [SW-1:0] n_wa, p_wa, m_wa, n_ra, p_ra, m_ra;
  logic [PW-1:0] n_wd, p_wd, n_rd, p_rd;
  logic          m_wd, m_rd;

  assign lx    = (uop == UOP_GRB_INIT) ? src_r : l_r;
  assign hd_x  = hd_r[lx];
  assign tl_x  = tl_r[lx];
  assign cnt_x = cnt_r[lx];
  assign e_ptr = {1'b0, e_r};
  assign sum   = {1'b0, cnt_x} + {1'b0, cs_r};

  mllqm_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
  );
  mllqm_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_prev_ram (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
  );
  mllqm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_member_ram (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  always_comb begin
    n_we = 1'b0; n_wa = slot_of(l_r, e_ptr); n_wd = LINK_NONE;
    p_we = 1'b0; p_wa = slot_of(l_r, e_ptr); p_wd = LINK_NONE;
    m_we = 1'b0; m_wa = slot_of(l_r, e_ptr); m_wd = 1'b0;
    n_ra = slot_of(l_r, e_ptr);
    p_ra = slot_of(l_r, e_ptr);
    m_ra = slot_of(l_r, e_ptr);
    lst_we  = 1'b0;
    lst_wi  = l_r;
    hd_nxt  = hd_x;
    tl_nxt  = tl_x;
    cnt_nxt = cnt_x;
    unique case (uop)
      UOP_INIT: begin
        n_we = 1'b1; n_wa = clr_addr_r;
        p_we = 1'b1; p_wa = clr_addr_r;
        m_we = 1'b1; m_wa = clr_addr_r;
      end
      UOP_PUSH_A: begin
        if (!m_rd) begin
          if ((cnt_x != '0) && (tl_x < LINK_NONE)) begin
            n_we = 1'b1; n_wa = slot_of(l_r, tl_x); n_wd = e_ptr;
          end
          p_we = 1'b1;
          p_wd = (cnt_x != '0) ? tl_x : LINK_NONE;
          m_we = 1'b1; m_wd = 1'b1;
        end
      end
      UOP_PUSH_B: begin
        n_we   = 1'b1;
        lst_we = 1'b1;
        if (cnt_x == '0) hd_nxt = e_ptr;
        tl_nxt = e_ptr;
        if (cnt_x < LINK_NONE) cnt_nxt = cnt_x + PW'(1);
      end
      UOP_REM_A: begin
        if ((cnt_x != '0) && m_rd) begin
          if (e_ptr == hd_x) hd_nxt = n_rd;
          if (e_ptr == tl_x) tl_nxt = p_rd;
          cnt_nxt = cnt_x - PW'(1);
          lst_we  = 1'b1;
          if (n_rd < LINK_NONE) begin
            p_we = 1'b1; p_wa = slot_of(l_r, n_rd); p_wd = p_rd;
          end
          if (p_rd < LINK_NONE) begin
            n_we = 1'b1; n_wa = slot_of(l_r, p_rd); n_wd = n_rd;
          end
          m_we = 1'b1;
        end
      end
      UOP_REM_B: begin
        n_we = 1'b1;
        p_we = 1'b1;
      end
      UOP_SHF_RD: n_ra = slot_of(l_r, hd_x);
      UOP_SHF_A: begin
        hd_nxt = n_rd;
        if (h_r == tl_x) tl_nxt = LINK_NONE;
        cnt_nxt = cnt_x - PW'(1);
        lst_we  = 1'b1;
        if (n_rd < LINK_NONE) begin
          p_we = 1'b1; p_wa = slot_of(l_r, n_rd);
        end
        n_we = 1'b1; n_wa = slot_of(l_r, h_r);
        m_we = 1'b1; m_wa = slot_of(l_r, h_r);
      end
      UOP_SHF_B: begin
        p_we = 1'b1; p_wa = slot_of(l_r, h_r);
      end
      UOP_CLR_RD: n_ra = slot_of(l_r, cur_r);
      UOP_CLR_DROP: begin
        n_we = 1'b1; n_wa = slot_of(l_r, cur_r);
        p_we = 1'b1; p_wa = slot_of(l_r, cur_r);
        m_we = 1'b1; m_wa = slot_of(l_r, cur_r);
      end
      UOP_CLR_END: begin
        lst_we = 1'b1; hd_nxt = LINK_NONE; tl_nxt = LINK_NONE; cnt_nxt = '0;
      end
      UOP_GRB_RD: begin
        n_ra = slot_of(src_r, cur_r);
        p_ra = slot_of(src_r, cur_r);
        m_ra = slot_of(src_r, cur_r);
      end
      UOP_GRB_CPY: begin
        n_we = 1'b1; n_wa = slot_of(l_r, cur_r); n_wd = n_rd;
        p_we = 1'b1; p_wa = slot_of(l_r, cur_r); p_wd = p_rd;
        m_we = 1'b1; m_wa = slot_of(l_r, cur_r); m_wd = m_rd;
      end
      UOP_GRB_DROP: begin
        n_we = 1'b1; n_wa = slot_of(src_r, cur_r);
        p_we = 1'b1; p_wa = slot_of(src_r, cur_r);
        m_we = 1'b1; m_wa = slot_of(src_r, cur_r);
      end
      UOP_GRB_LINK: begin
        lst_we = 1'b1;
        tl_nxt = ts_r;
        if (cnt_x != '0) begin
          if (tl_x < LINK_NONE) begin
            n_we = 1'b1; n_wa = slot_of(l_r, tl_x); n_wd = hs_r;
          end
          if (hs_r < LINK_NONE) begin
            p_we = 1'b1; p_wa = slot_of(l_r, hs_r); p_wd = tl_x;
          end
        end else begin
          hd_nxt = hs_r;
        end
        cnt_nxt = (sum > (PW+1)'(NUM_ENTRIES)) ? LINK_NONE : sum[PW-1:0];
      end
      UOP_GRB_EMPTY: begin
        lst_we = 1'b1; lst_wi = src_r;
        hd_nxt = LINK_NONE; tl_nxt = LINK_NONE; cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        hd_r[i]  <= LINK_NONE;
        tl_r[i]  <= LINK_NONE;
        cnt_r[i] <= '0;
      end
      clr_addr_r <= '0;
    end else begin
      if (lst_we) begin
        hd_r[lst_wi]  <= hd_nxt;
        tl_r[lst_wi]  <= tl_nxt;
        cnt_r[lst_wi] <= cnt_nxt;
      end
      if (uop == UOP_INIT) clr_addr_r <= clr_addr_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (uop)
      UOP_LOAD: begin
        l_r     <= in_list_id;
        e_r     <= in_entry_index;
        src_r   <= in_source_list_id;
        valid_r <= 1'b0;
        pop_r   <= '0;
      end
      UOP_SHF_RD: h_r <= hd_x;
      UOP_SHF_A: begin
        valid_r <= 1'b1;
        pop_r   <= h_r[EW-1:0];
      end
      UOP_CLR_INIT: begin
        cur_r   <= hd_x;
        steps_r <= '0;
      end
      UOP_CLR_DROP: begin
        cur_r   <= n_rd;
        steps_r <= steps_r + PW'(1);
      end
      UOP_GRB_INIT: begin
        cur_r   <= hd_x;
        hs_r    <= hd_x;
        ts_r    <= tl_x;
        cs_r    <= cnt_x;
        steps_r <= '0;
      end
      UOP_GRB_CPY: n_r <= n_rd;
      UOP_GRB_DROP: begin
        cur_r   <= n_r;
        steps_r <= steps_r + PW'(1);
      end
      default: ;
    endcase
  end

  assign status.mbr       = m_rd;
  assign status.cnt_zero  = (cnt_x == '0);
  assign status.hd_none   = (hd_x >= LINK_NONE);
  assign status.walk_done = (cur_r >= LINK_NONE) || (steps_r == PW'(NUM_ENTRIES));
  assign status.same_list = (l_r == src_r);
  assign status.init_done = (clr_addr_r == SW'(SLOTS - 1));

  assign out_result_entry = pop_r;
  assign out_result_valid = valid_r;
  assign out_is_member    = m_rd;
  assign out_list_size    = cnt_x;
  assign out_list_head    = hd_x;
  assign out_list_tail    = tl_x;

  `CHK_IMP(a_shift_nonempty, uop == UOP_SHF_A, cnt_x != '0, "pop issued on an empty list")
  `CHK_IMP(a_count_bound, 1'b1, cnt_x <= LINK_NONE, "list count above pool size")

endmodule

>>> rtl/core/multi_list_linked_queue_manager.sv
// Top level of the multi-list linked queue manager.
//
// Usage: four ordered lists share one pool of 256 entries, each list with its
// own next/prev links, membership flags, head, tail and count.
// Command channel: drive in_command, in_list_id, in_entry_index and
// in_source_list_id with start high; the transfer is taken on a rising edge
// with start high and busy low. One command is worked at a time.
// Result channel: out_strobe is high for exactly one cycle with the result;
// the receiver cannot hold it off, so capture it on that edge.
// From the accepting edge to the strobe, each command ends in a final read:
//   contains and unused codes do only that; push, remove and shift read
//   first, then update if the command applies; clear walks the list, grab
//   the source list, skipped when the source is empty or is the destination.
// Each walk step reads, then writes (grab copies, then drops), as the link
// memories register their read data. Busy falls in the cycle after the strobe.
// Reset: synchronous, active low. After reset all 1024 link memory slots are
// swept, one slot a cycle, with busy high; commands wait until then.
module multi_list_linked_queue_manager import mllqm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_command,
  input  logic [1:0] in_list_id,
  input  logic [7:0] in_entry_index,
  input  logic [1:0] in_source_list_id,
  output logic       out_strobe,
  output logic [7:0] out_result_entry,
  output logic       out_result_valid,
  output logic       out_is_member,
  output logic [8:0] out_list_size,
  output logic [8:0] out_list_head,
  output logic [8:0] out_list_tail
);

  // Micro-op from the sequencer, status flags back from the datapath.
  logic [UW-1:0] uop;
  dp_status_t    status;

  // Sequence each command and hold off new transfers while one is in flight.
  mllqm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .command    (in_command),
    .status     (status),
    .uop        (uop),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // Hold the lists and links; present the addressed list during the strobe.
  mllqm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .uop               (uop),
    .in_list_id        (in_list_id),
    .in_entry_index    (in_entry_index),
    .in_source_list_id (in_source_list_id),
    .status            (status),
    .out_result_entry  (out_result_entry),
    .out_result_valid  (out_result_valid),
    .out_is_member     (out_is_member),
    .out_list_size     (out_list_size),
    .out_list_head     (out_list_head),
    .out_list_tail     (out_list_tail)
  );

endmodule

>>> tb/tb_multi_list_linked_queue_manager.sv
// Self-checking testbench for the multi-list linked queue manager.
module tb_multi_list_linked_queue_manager;
  import mllqm_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_command;
  logic [1:0] in_list_id;
  logic [7:0] in_entry_index;
  logic [1:0] in_source_list_id;
  logic       out_strobe;
  logic [7:0] out_result_entry;
  logic       out_result_valid;
  logic       out_is_member;
  logic [8:0] out_list_size;
  logic [8:0] out_list_head;
  logic [8:0] out_list_tail;

  multi_list_linked_queue_manager dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_list_id(in_list_id),
    .in_entry_index(in_entry_index), .in_source_list_id(in_source_list_id),
    .out_strobe(out_strobe), .out_result_entry(out_result_entry),
    .out_result_valid(out_result_valid), .out_is_member(out_is_member),
    .out_list_size(out_list_size), .out_list_head(out_list_head),
    .out_list_tail(out_list_tail)
  );

  // One list report as the block presents it.
  typedef struct packed {
    logic [7:0] popped;
    logic       popped_ok;
    logic       member;
    logic [8:0] size;
    logic [8:0] head;
    logic [8:0] tail;
  } report_t;

  // One command row of the directed table; has_fixed marks a typed-in answer.
  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] lst;
    logic [7:0] ent;
    logic [1:0] src;
    logic       has_fixed;
    report_t    fixed;
  } row_t;

  // Shadow copy of the list stores.
  int         nxt_sh  [SLOTS];
  int         prv_sh  [SLOTS];
  logic       mbr_sh  [SLOTS];
  int         head_sh [NUM_LISTS];
  int         tail_sh [NUM_LISTS];
  int         cnt_sh  [NUM_LISTS];

  report_t pending_reports[$];
  int      n_errors;
  int      cycle_count;
  int      send_idle_pct;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Bound the run well above 1200 full-list grabs plus the sweep.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 5000000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int slot_ix(input int l, input int e);
    return l * NUM_ENTRIES + e;
  endfunction

  function automatic void shadow_drop(input int s);
    nxt_sh[s] = NUM_ENTRIES;
    prv_sh[s] = NUM_ENTRIES;
    mbr_sh[s] = 1'b0;
  endfunction

  function automatic void shadow_empty(input int l);
    head_sh[l] = NUM_ENTRIES;
    tail_sh[l] = NUM_ENTRIES;
    cnt_sh[l]  = 0;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < SLOTS; i++) shadow_drop(i);
    for (int i = 0; i < NUM_LISTS; i++) shadow_empty(i);
  endfunction

  // Apply one command to the shadow and return the report it should give.
  function automatic report_t apply_command(input logic [2:0] cmd, input int l,
                                            input int e, input int src);
    report_t r;
    int s, cur, steps, n, p, ss, ds, t, h, sum;
    r = '0;
    s = slot_ix(l, e);
    case (cmd)
      CMD_PUSH: begin
        if (!mbr_sh[s]) begin
          t = tail_sh[l];
          if (cnt_sh[l] > 0) begin
            if (t < NUM_ENTRIES) nxt_sh[slot_ix(l, t)] = e;
            prv_sh[s] = t;
          end else begin
            head_sh[l] = e;
            prv_sh[s] = NUM_ENTRIES;
          end
          nxt_sh[s] = NUM_ENTRIES;
          tail_sh[l] = e;
          mbr_sh[s] = 1'b1;
          if (cnt_sh[l] < NUM_ENTRIES) cnt_sh[l]++;
        end
      end
      CMD_REMOVE: begin
        if (cnt_sh[l] != 0 && mbr_sh[s]) begin
          n = nxt_sh[s];
          p = prv_sh[s];
          if (e == head_sh[l]) head_sh[l] = n;
          if (e == tail_sh[l]) tail_sh[l] = p;
          if (n < NUM_ENTRIES) prv_sh[slot_ix(l, n)] = p;
          if (p < NUM_ENTRIES) nxt_sh[slot_ix(l, p)] = n;
          shadow_drop(s);
          cnt_sh[l]--;
        end
      end
      CMD_SHIFT: begin
        h = head_sh[l];
        if (cnt_sh[l] != 0 && h < NUM_ENTRIES) begin
          ss = slot_ix(l, h);
          head_sh[l] = nxt_sh[ss];
          if (h == tail_sh[l]) tail_sh[l] = NUM_ENTRIES;
          if (head_sh[l] < NUM_ENTRIES) prv_sh[slot_ix(l, head_sh[l])] = NUM_ENTRIES;
          cnt_sh[l]--;
          shadow_drop(ss);
          r.popped = 8'(h);
          r.popped_ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        cur = head_sh[l];
        steps = 0;
        while (cur < NUM_ENTRIES && steps < NUM_ENTRIES) begin
          ss = slot_ix(l, cur);
          n = nxt_sh[ss];
          shadow_drop(ss);
          cur = n;
          steps++;
        end
        shadow_empty(l);
      end
      CMD_GRAB: begin
        if (l != src && cnt_sh[src] != 0) begin
          cur = head_sh[src];
          steps = 0;
          // A shared entry gets its destination links overwritten here.
          while (cur < NUM_ENTRIES && steps < NUM_ENTRIES) begin
            ss = slot_ix(src, cur);
            ds = slot_ix(l, cur);
            nxt_sh[ds] = nxt_sh[ss];
            prv_sh[ds] = prv_sh[ss];
            mbr_sh[ds] = mbr_sh[ss];
            shadow_drop(ss);
            cur = nxt_sh[ds];
            steps++;
          end
          if (cnt_sh[l] > 0) begin
            t = tail_sh[l];
            h = head_sh[src];
            if (t < NUM_ENTRIES) nxt_sh[slot_ix(l, t)] = h;
            if (h < NUM_ENTRIES) prv_sh[slot_ix(l, h)] = t;
            tail_sh[l] = tail_sh[src];
          end else begin
            head_sh[l] = head_sh[src];
            tail_sh[l] = tail_sh[src];
          end
          sum = cnt_sh[l] + cnt_sh[src];
          cnt_sh[l] = (sum > NUM_ENTRIES) ? NUM_ENTRIES : sum;
          shadow_empty(src);
        end
      end
      default: ;
    endcase
    r.member = mbr_sh[s];
    r.size   = 9'(cnt_sh[l]);
    r.head   = 9'(head_sh[l]);
    r.tail   = 9'(tail_sh[l]);
    return r;
  endfunction

  // Drive one command, hold it until the block takes the transfer, then
  // drop start and wait for the next edge while the block is still busy.
  task automatic issue(input logic [2:0] cmd, input logic [1:0] l,
                       input logic [7:0] e, input logic [1:0] src,
                       input logic has_fixed, input report_t fixed);
    report_t r;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    start             <= 1'b1;
    in_command        <= cmd;
    in_list_id        <= l;
    in_entry_index    <= e;
    in_source_list_id <= src;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Transfer taken on this edge: predict now so the order matches.
    r = apply_command(cmd, int'(l), int'(e), int'(src));
    if (has_fixed && r != fixed)
      $display("%0t table row disagrees with shadow: table %h shadow %h", $time, fixed, r);
    pending_reports.push_front(has_fixed ? fixed : r);
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Compare every strobed result with the oldest pending report.
  always @(posedge clk) begin
    report_t got, want;
    if (rst_n && out_strobe) begin
      got = '{out_result_entry, out_result_valid, out_is_member,
              out_list_size, out_list_head, out_list_tail};
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        n_errors++;
      end else begin
        want = pending_reports.pop_back();
        if (got.popped !== want.popped)
          $display("%0t result_entry exp %0d got %0d", $time, want.popped, got.popped);
        if (got.popped_ok !== want.popped_ok)
          $display("%0t result_valid exp %0d got %0d", $time, want.popped_ok, got.popped_ok);
        if (got.member !== want.member)
          $display("%0t is_member exp %0d got %0d", $time, want.member, got.member);
        if (got.size !== want.size)
          $display("%0t list_size exp %0d got %0d", $time, want.size, got.size);
        if (got.head !== want.head)
          $display("%0t list_head exp %0d got %0d", $time, want.head, got.head);
        if (got.tail !== want.tail)
          $display("%0t list_tail exp %0d got %0d", $time, want.tail, got.tail);
        if (got !== want) n_errors++;
      end
    end
  end

  function automatic row_t mk(input logic [2:0] c, input logic [1:0] l,
                              input logic [7:0] e, input logic [1:0] s);
    return '{c, l, e, s, 1'b0, '0};
  endfunction

  function automatic row_t mkf(input logic [2:0] c, input logic [1:0] l,
                               input logic [7:0] e, input logic [1:0] s,
                               input report_t f);
    return '{c, l, e, s, 1'b1, f};
  endfunction

  // Pick an entry mostly from a small band so that lists fill and collide.
  function automatic logic [7:0] pick_entry();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 8'($urandom_range(255));
    if (k == 1) return 8'(255 - $urandom_range(3));
    return 8'($urandom_range(15));
  endfunction

  task automatic random_phase(input int n_items, input int idle_pct);
    logic [2:0] c;
    int k;
    send_idle_pct = idle_pct;
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(99);
      if      (k < 38) c = CMD_PUSH;
      else if (k < 55) c = CMD_REMOVE;
      else if (k < 70) c = CMD_SHIFT;
      else if (k < 82) c = CMD_CONTAINS;
      else if (k < 86) c = CMD_CLEAR;
      else if (k < 96) c = CMD_GRAB;
      else             c = 3'($urandom_range(7));
      issue(c, 2'($urandom_range(3)), pick_entry(), 2'($urandom_range(3)), 1'b0, '0);
    end
  endtask

  task automatic drain();
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  localparam logic [8:0] NONE9 = LINK_NONE;

  initial begin
    row_t rows[$];
    n_errors = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = '0;
    in_list_id = '0;
    in_entry_index = '0;
    in_source_list_id = '0;
    shadow_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: fresh state, extremes, every command and odd case.
    rows = {rows, mkf(CMD_CONTAINS, 2'd3, 8'd255, 2'd0,
                      '{8'd0, 1'b0, 1'b0, 9'd0, NONE9, NONE9})};
    rows = {rows, mkf(CMD_SHIFT,    2'd0, 8'd0,   2'd0,
                      '{8'd0, 1'b0, 1'b0, 9'd0, NONE9, NONE9})};
    rows = {rows, mkf(CMD_REMOVE,   2'd1, 8'd7,   2'd0,
                      '{8'd0, 1'b0, 1'b0, 9'd0, NONE9, NONE9})};
    rows = {rows, mkf(CMD_PUSH,     2'd0, 8'd0,   2'd3,
                      '{8'd0, 1'b0, 1'b1, 9'd1, 9'd0, 9'd0})};
    rows = {rows, mkf(CMD_PUSH,     2'd0, 8'd255, 2'd0,
                      '{8'd0, 1'b0, 1'b1, 9'd2, 9'd0, 9'd255})};
    rows = {rows, mk(CMD_PUSH,      2'd0, 8'd255, 2'd0)};
    rows = {rows, mk(CMD_PUSH,      2'd0, 8'd170, 2'd0)};
    rows = {rows, mk(CMD_PUSH,      2'd0, 8'd85,  2'd0)};
    rows = {rows, mk(CMD_REMOVE,    2'd0, 8'd170, 2'd0)};
    rows = {rows, mk(CMD_CONTAINS,  2'd0, 8'd170, 2'd0)};
    rows = {rows, mk(3'd6,          2'd0, 8'd0,   2'd0)};
    rows = {rows, mk(3'd7,          2'd2, 8'd85,  2'd1)};
    rows = {rows, mk(CMD_PUSH,      2'd3, 8'd1,   2'd0)};
    rows = {rows, mk(CMD_PUSH,      2'd3, 8'd2,   2'd0)};
    rows = {rows, mk(CMD_GRAB,      2'd3, 8'd1,   2'd3)};
    rows = {rows, mk(CMD_GRAB,      2'd2, 8'd0,   2'd1)};
    rows = {rows, mk(CMD_GRAB,      2'd3, 8'd0,   2'd0)};
    rows = {rows, mk(CMD_PUSH,      2'd1, 8'd85,  2'd0)};
    rows = {rows, mk(CMD_PUSH,      2'd1, 8'd9,   2'd0)};
    rows = {rows, mk(CMD_GRAB,      2'd1, 8'd85,  2'd3)};
    rows = {rows, mk(CMD_SHIFT,     2'd1, 8'd85,  2'd0)};
    rows = {rows, mk(CMD_REMOVE,    2'd1, 8'd9,   2'd0)};
    rows = {rows, mk(CMD_CLEAR,     2'd1, 8'd0,   2'd0)};
    rows = {rows, mkf(CMD_CLEAR,    2'd3, 8'd0,   2'd0,
                      '{8'd0, 1'b0, 1'b0, 9'd0, NONE9, NONE9})};
    foreach (rows[i])
      issue(rows[i].cmd, rows[i].lst, rows[i].ent, rows[i].src,
            rows[i].has_fixed, rows[i].fixed);

    // Hold off until everything is back before the random part.
    drain();

    // Fill one list to all 256 entries once, then grab it across.
    send_idle_pct = 0;
    for (int i = 0; i < 256; i++) issue(CMD_PUSH, 2'd2, 8'(i), 2'd0, 1'b0, '0);
    issue(CMD_GRAB, 2'd0, 8'd255, 2'd2, 1'b0, '0);
    issue(CMD_CLEAR, 2'd0, 8'd0, 2'd0, 1'b0, '0);

    random_phase(300, 20);
    drain();
    random_phase(300, 86);
    random_phase(300, 0);

    drain();
    repeat (800) @(posedge clk);
    if (n_errors == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
